// ===== hw/rtl/sdes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdes_pkg
// Shared widths, types, register indexes and round functions for the
// 12-bit block, 9-bit key Feistel cipher.
// ----------------------------------------------------------------------------
package sdes_pkg;

   localparam int BLOCK_W        = 12;
   localparam int HALF_W         = 6;
   localparam int KEY_W          = 9;
   localparam int RKEY_W         = 8;
   localparam int ROUND_CNT_W    = 4;
   localparam int ROT_W          = 4;
   localparam int KEY_LEN        = 9;
   localparam int MAX_ROUNDS_DEF = 8;
   localparam int DATA_BYTES_W   = 16;

   // register indexes of the write port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CIPHER_KEY  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_COUNT = 1'b1;

   typedef struct packed {
      logic               mode;   // 1 encrypt, 0 decrypt
      logic [BLOCK_W-1:0] block;
   } sdes_item_type;

   function automatic logic [2:0] sbox1(input logic row, input logic [2:0] col);
      logic [2:0] v;
      case (col)
         3'd0:    v = row ? 3'd1 : 3'd5;
         3'd1:    v = row ? 3'd4 : 3'd2;
         3'd2:    v = row ? 3'd6 : 3'd1;
         3'd3:    v = row ? 3'd2 : 3'd6;
         3'd4:    v = row ? 3'd0 : 3'd3;
         3'd5:    v = row ? 3'd7 : 3'd4;
         3'd6:    v = row ? 3'd5 : 3'd7;
         3'd7:    v = row ? 3'd3 : 3'd0;
         default: v = 3'd0;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] sbox2(input logic row, input logic [2:0] col);
      logic [2:0] v;
      case (col)
         3'd0:    v = row ? 3'd5 : 3'd4;
         3'd1:    v = row ? 3'd3 : 3'd0;
         3'd2:    v = row ? 3'd0 : 3'd6;
         3'd3:    v = row ? 3'd7 : 3'd5;
         3'd4:    v = row ? 3'd6 : 3'd7;
         3'd5:    v = row ? 3'd2 : 3'd1;
         3'd6:    v = row ? 3'd1 : 3'd3;
         3'd7:    v = row ? 3'd4 : 3'd2;
         default: v = 3'd0;
      endcase
      return v;
   endfunction

   // rotate the 9-bit key left by s (s below 9), keep bits 8:1
   function automatic logic [RKEY_W-1:0] rotl_subkey(input logic [KEY_W-1:0] key,
                                                     input logic [ROT_W-1:0] s);
      logic [2*KEY_W-1:0] dbl;
      dbl = {key, key} << s;
      return dbl[2*KEY_W-1 -: RKEY_W];
   endfunction

   function automatic logic [HALF_W-1:0] ffunc(input logic [HALF_W-1:0] r,
                                               input logic [RKEY_W-1:0] rkey);
      logic [RKEY_W-1:0] e;
      e = {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]} ^ rkey;
      return {sbox1(e[7], e[6:4]), sbox2(e[3], e[2:0])};
   endfunction

endpackage : sdes_pkg
`default_nettype wire

// ===== hw/rtl/sdes_round_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdes_round_cell
// One pipeline cell: applies the round that falls on its position, or passes
// the block through when the position lies beyond the configured count.
// ----------------------------------------------------------------------------
module sdes_round_cell #(
   parameter int MAX_ROUNDS = sdes_pkg::MAX_ROUNDS_DEF,
   parameter int STEP       = 1
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic [$clog2(MAX_ROUNDS+1)-1:0]          n_rounds,
   input  wire logic [sdes_pkg::KEY_W-1:0]               cipher_key,
   input  wire logic                                     up_valid,
   output logic                                          up_ready,
   input  wire sdes_pkg::sdes_item_type                  up_item,
   output logic                                          dn_valid,
   input  wire logic                                     dn_ready,
   output sdes_pkg::sdes_item_type                       dn_item
);
   import sdes_pkg::*;

   localparam int CNT_W = $clog2(MAX_ROUNDS+1);
   localparam logic [CNT_W-1:0] STEP_V = CNT_W'(STEP);
   localparam logic [CNT_W-1:0] ONE_V  = CNT_W'(1);

   logic                 valid_ff, valid_in;
   sdes_item_type        item_ff, item_in;
   logic [CNT_W-1:0]     round_idx, shift_raw, shift_mod;
   logic                 active, last;
   logic [RKEY_W-1:0]    rkey;
   logic [HALF_W-1:0]    l_half, r_half, new_r;

   always_comb begin
      // decrypt walks the keys from the top down
      round_idx = up_item.mode ? STEP_V : (n_rounds - STEP_V + ONE_V);
      shift_raw = round_idx - ONE_V;
      // wrap the rotation at the key length
      shift_mod = (int'(shift_raw) >= KEY_LEN) ? CNT_W'(int'(shift_raw) - KEY_LEN)
                                               : shift_raw;
      active    = (STEP_V <= n_rounds);
      last      = (STEP_V == n_rounds);
      rkey      = rotl_subkey(cipher_key, ROT_W'(shift_mod));
      l_half    = up_item.block[BLOCK_W-1:HALF_W];
      r_half    = up_item.block[HALF_W-1:0];
      new_r     = l_half ^ ffunc(r_half, rkey);

      item_in.mode = up_item.mode;
      if (!active) begin
         item_in.block = up_item.block;
      end else if (last) begin
         item_in.block = {new_r, r_half};
      end else begin
         item_in.block = {r_half, new_r};
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule : sdes_round_cell
`default_nettype wire

// ===== hw/rtl/simplified_des_block_cipher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// simplified_des_block_cipher_unit
// 12-bit block, 9-bit key Feistel cipher as a chain of round cells.
// ----------------------------------------------------------------------------
// One block is accepted per clock and one result leaves per clock when the
// result side keeps rsp_tready high. The chain holds one registered cell per
// possible round, and the last cell's register is the output register. Each
// cell applies its round when its position is within the configured count
// and otherwise hands the block through. Every cell stalls only when it is
// full and its neighbor downstream is full and stalled, so bubbles collapse
// and input transfers continue while a result waits. round_count above
// MAX_ROUNDS runs MAX_ROUNDS rounds; round_count 0 returns a zero block.
// Write cipher_key and round_count only while no transfer is in flight.
// ----------------------------------------------------------------------------
module simplified_des_block_cipher_unit #(
   parameter int MAX_ROUNDS = sdes_pkg::MAX_ROUNDS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [sdes_pkg::DATA_BYTES_W-1:0]    req_tdata,  // [11:0] block_in
   input  wire logic                                 req_tuser,  // [0] mode
   // response stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [sdes_pkg::DATA_BYTES_W-1:0]         rsp_tdata,  // [11:0] block_out
   // register write port
   input  wire logic                                 csr_wr_en,
   input  wire logic [sdes_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sdes_pkg::KEY_W-1:0]           csr_wdata
);
   import sdes_pkg::*;

   localparam int CNT_W = $clog2(MAX_ROUNDS+1);
   localparam int CMP_W = ROUND_CNT_W + 1;

   logic [KEY_W-1:0]       cipher_key_ff, cipher_key_in;
   logic [ROUND_CNT_W-1:0] round_count_ff, round_count_in;
   logic [CMP_W-1:0]       rc_wide;
   logic [CNT_W-1:0]       n_rounds;

   // chain links: index 0 is the request side, MAX_ROUNDS the output
   logic          link_valid [MAX_ROUNDS+1];
   logic          link_ready [MAX_ROUNDS+1];
   sdes_item_type link_item  [MAX_ROUNDS+1];

   // configuration registers
   always_comb begin
      cipher_key_in  = cipher_key_ff;
      round_count_in = round_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CIPHER_KEY:  cipher_key_in  = csr_wdata;
            CSR_ROUND_COUNT: round_count_in = csr_wdata[ROUND_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_key_ff  <= '0;
         round_count_ff <= ROUND_CNT_W'(4);
      end else begin
         cipher_key_ff  <= cipher_key_in;
         round_count_ff <= round_count_in;
      end
   end

   // saturate the round count to the chain length
   always_comb begin
      rc_wide  = {1'b0, round_count_ff};
      n_rounds = (rc_wide > CMP_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS) : CNT_W'(rc_wide);
   end

   // feed the chain; with no rounds configured the block drops to zero
   assign link_valid[0]      = req_tvalid;
   assign req_tready         = link_ready[0];
   assign link_item[0].mode  = req_tuser;
   assign link_item[0].block = (n_rounds == '0) ? '0 : req_tdata[BLOCK_W-1:0];

   for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_cell
      sdes_round_cell #(
         .MAX_ROUNDS (MAX_ROUNDS),
         .STEP       (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .n_rounds   (n_rounds),
         .cipher_key (cipher_key_ff),
         .up_valid   (link_valid[g-1]),
         .up_ready   (link_ready[g-1]),
         .up_item    (link_item[g-1]),
         .dn_valid   (link_valid[g]),
         .dn_ready   (link_ready[g]),
         .dn_item    (link_item[g])
      );
   end

   // last cell register drives the response stream
   assign rsp_tvalid             = link_valid[MAX_ROUNDS];
   assign link_ready[MAX_ROUNDS] = rsp_tready;
   assign rsp_tdata = {{(DATA_BYTES_W-BLOCK_W){1'b0}}, link_item[MAX_ROUNDS].block};

endmodule : simplified_des_block_cipher_unit
`default_nettype wire
